// File: rtl/gmdpt_pkg.sv
package gmdpt_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;
    localparam int DIST_BITS  = 24;
    localparam int ADDR_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int POINT_BITS = 3 * COORD_BITS;
    localparam int ABS_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIST_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } gmdpt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
        logic out_free;
    } gmdpt_status_t;

endpackage

// File: rtl/gmdpt_if.sv
interface gmdpt_point_if
    import gmdpt_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         first_of_set;

    modport source (output valid, pos_x, pos_y, pos_z, first_of_set, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, first_of_set, output ready);
endinterface

interface gmdpt_result_if
    import gmdpt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                keep;
    logic                store_full;
    logic [CNT_BITS-1:0] kept_total;

    modport source (output valid, keep, store_full, kept_total, input ready);
    modport sink   (input valid, keep, store_full, kept_total, output ready);
endinterface

// File: rtl/greedy_min_distance_point_thinning.sv
// channel   dir  handshake     payload
// points    in   valid/ready   pos_x, pos_y, pos_z (s24 Q16.8), first_of_set
// results   out  valid/ready   keep, store_full, kept_total (u11)
// cfg       in   cfg_we        cfg_wdata = min_distance (u24 Q16.8)
//
// With N points kept in the set, the store RAM is read once a cycle, N reads in all, and each
// read passes a three-stage compare pipeline (abs difference, squares, sum and test).
// The result beat is offered once the last compare has retired and the result register is
// free; the controller is back in idle as it is offered, so the next point can be taken then.
// A finished point waits for the result register while the previous beat is held.
// Reset clears the kept count, the output valid and min_distance, but not the store.
module greedy_min_distance_point_thinning
    import gmdpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [DIST_BITS-1:0] cfg_wdata,
    gmdpt_point_if.sink          points,
    gmdpt_result_if.source       results
);

    gmdpt_cmd_t    cmd;
    gmdpt_status_t status;

    // sequence the load, scan and commit of each point beat
    gmdpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (points.valid),
        .in_ready (points.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold the store, the count and the compare pipeline; drive the result beat
    gmdpt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .pos_x        (points.pos_x),
        .pos_y        (points.pos_y),
        .pos_z        (points.pos_z),
        .first_of_set (points.first_of_set),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .keep         (results.keep),
        .store_full   (results.store_full),
        .kept_total   (results.kept_total)
    );

endmodule

// File: rtl/gmdpt_ram.sv
module gmdpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/gmdpt_ctrl.sv
module gmdpt_ctrl
    import gmdpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gmdpt_status_t status,
    output gmdpt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last compare to retire and the result slot to open
                if (!status.pipe_busy && status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/gmdpt_datapath.sv
module gmdpt_datapath
    import gmdpt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [DIST_BITS-1:0]         cfg_wdata,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic                         first_of_set,
    input  gmdpt_cmd_t                   cmd,
    output gmdpt_status_t                status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         keep,
    output logic                         store_full,
    output logic [CNT_BITS-1:0]          kept_total
);

    logic [DIST_BITS-1:0] dist_reg;
    logic [SQ_BITS-1:0]   dsq_reg;
    point_t               pt_reg;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic                 hit_reg, hit_next;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [ABS_BITS-1:0]  adx_reg, ady_reg, adz_reg;
    logic                 far_reg;
    logic [SQ_BITS-1:0]   sqx_reg, sqy_reg, sqz_reg;

    logic                 out_valid_reg, out_valid_next;
    logic                 keep_reg, full_reg;
    logic [CNT_BITS-1:0]  total_reg;

    logic [POINT_BITS-1:0] rdata;
    point_t               rd_pt;
    logic                 full_now;
    logic                 wr_en;
    logic [ABS_BITS-1:0]  adx, ady, adz;
    logic [SUM_BITS-1:0]  sum;
    logic                 close;

    gmdpt_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_BITS-1:0]),
        .wdata (pt_reg),
        .re    (cmd.issue),
        .raddr (idx_reg[ADDR_BITS-1:0]),
        .rdata (rdata)
    );

    assign rd_pt    = point_t'(rdata);
    assign full_now = (count_reg == CNT_BITS'(MAX_POINTS));
    assign wr_en    = cmd.commit && !hit_reg && !full_now;

    function automatic logic [ABS_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [ABS_BITS-1:0] d;
        d = ABS_BITS'(a) - ABS_BITS'(b);
        return d[ABS_BITS-1] ? ABS_BITS'(-d) : ABS_BITS'(d);
    endfunction

    assign adx = abs_diff(pt_reg.x, rd_pt.x);
    assign ady = abs_diff(pt_reg.y, rd_pt.y);
    assign adz = abs_diff(pt_reg.z, rd_pt.z);

    assign sum   = SUM_BITS'(sqx_reg) + SUM_BITS'(sqy_reg) + SUM_BITS'(sqz_reg);
    assign close = v3_reg && !far_reg && (sum < SUM_BITS'(dsq_reg));

    assign status.scan_done = (idx_reg == count_reg);
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg || close;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load)
        begin
            idx_next = '0;
            hit_next = 1'b0;
            if (first_of_set)
            begin
                count_next = '0;
            end
        end
        if (cmd.issue)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            if (wr_en)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dist_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pt_reg.x <= pos_x;
            pt_reg.y <= pos_y;
            pt_reg.z <= pos_z;
            dsq_reg  <= dist_reg * dist_reg;
        end
        adx_reg <= adx;
        ady_reg <= ady;
        adz_reg <= adz;
        far_reg <= (adx_reg >= ABS_BITS'(dist_reg)) || (ady_reg >= ABS_BITS'(dist_reg))
                   || (adz_reg >= ABS_BITS'(dist_reg));
        sqx_reg <= adx_reg[DIST_BITS-1:0] * adx_reg[DIST_BITS-1:0];
        sqy_reg <= ady_reg[DIST_BITS-1:0] * ady_reg[DIST_BITS-1:0];
        sqz_reg <= adz_reg[DIST_BITS-1:0] * adz_reg[DIST_BITS-1:0];
        if (cmd.commit)
        begin
            keep_reg  <= wr_en;
            full_reg  <= !hit_reg && full_now;
            total_reg <= wr_en ? count_reg + 1'b1 : count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign keep       = keep_reg;
    assign store_full = full_reg;
    assign kept_total = total_reg;

endmodule
